// File: src/shelf_atlas_packer_dedup_macros.svh
`ifndef SHELF_ATLAS_PACKER_DEDUP_MACROS_SVH
`define SHELF_ATLAS_PACKER_DEDUP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SAPD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sapd_pkg.sv
package sapd_pkg;

  localparam int unsigned KeyW     = 64;
  localparam int unsigned DimW     = 14;
  localparam int unsigned PadW     = 8;
  localparam int unsigned RowWW    = 15;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned XOutW    = 15;
  localparam int unsigned SumW     = 17;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned MaxKeysDefault = 64;

  localparam logic [CfgIdxW-1:0] CFG_ATLAS_PADDING = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ROW_WIDTH = 8'd1;

  localparam logic [PadW-1:0]  PadReset  = 8'd2;
  localparam logic [RowWW-1:0] RowWReset = 15'd2048;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ADVANCE,
    ST_WRAP,
    ST_PLACE,
    ST_FINAL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0] image_key;
    logic            image_present;
    logic [DimW-1:0] image_width;
    logic [DimW-1:0] image_height;
    logic            last_item;
  } item_t;

  typedef struct packed {
    logic              placed;
    logic [XOutW-1:0]  place_x;
    logic [CoordW-1:0] place_y;
    logic              is_final;
    logic              atlas_empty;
    logic [XOutW-1:0]  atlas_width;
    logic [CoordW-1:0] atlas_height;
    logic              overflow;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] value;
  } cfg_t;

  typedef struct packed {
    logic [CoordW-1:0] a;
    logic [DimW-1:0]   b;
    logic [PadW-1:0]   c;
  } alu_op_t;

  typedef struct packed {
    logic [SumW-1:0]   sum;
    logic              sat;
    logic [CoordW-1:0] sat_val;
  } alu_res_t;

endpackage

// File: src/sapd_intf.sv
interface sapd_item_if;
  logic            valid;
  logic            ready;
  sapd_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sapd_res_if;
  logic              valid;
  logic              ready;
  sapd_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sapd_cfg_if;
  logic           valid;
  logic           ready;
  sapd_pkg::cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/sapd_adder.sv
module sapd_adder (
  input  sapd_pkg::alu_op_t  op_i,
  output sapd_pkg::alu_res_t res_o
);

  logic [sapd_pkg::SumW-1:0] sum;

  assign sum = sapd_pkg::SumW'(op_i.a) + sapd_pkg::SumW'(op_i.b)
             + sapd_pkg::SumW'(op_i.c);

  assign res_o.sum     = sum;
  assign res_o.sat     = sum[sapd_pkg::SumW-1];
  assign res_o.sat_val = sum[sapd_pkg::SumW-1] ? '1 : sum[sapd_pkg::CoordW-1:0];

endmodule

// File: src/sapd_key_store.sv
module sapd_key_store #(
  parameter  int unsigned MAX_KEYS = sapd_pkg::MaxKeysDefault,
  localparam int unsigned AddrW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [sapd_pkg::KeyW-1:0] wr_key_i,
  input  logic                      rd_en_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  output logic [sapd_pkg::KeyW-1:0] rd_key_o
);

  logic [sapd_pkg::KeyW-1:0] mem_q [MAX_KEYS];
  logic [sapd_pkg::KeyW-1:0] rd_key_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_key_o = rd_key_q;

endmodule

// File: src/shelf_atlas_packer_dedup.sv
// Next-fit shelf packer for an atlas, with duplicate keys dropped. One image
// is taken per transfer and one result is returned per image; the item flagged
// last also carries the atlas size, after which the list state clears. The
// block holds one image at a time: an absent image skips the key search and a
// present one compares its key with the keys already stored in this list (at
// most MAX_KEYS). The key store is read one entry per cycle and every
// coordinate update goes through a single shared adder. A finished result
// sits in an output register, so the next image is taken while it waits.
// Configuration writes are taken at any time.
`include "shelf_atlas_packer_dedup_macros.svh"

module shelf_atlas_packer_dedup #(
  parameter int unsigned MAX_KEYS = sapd_pkg::MaxKeysDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sapd_cfg_if.sink     cfg_i,
  sapd_item_if.sink    img_i,
  sapd_res_if.source   res_o
);

  localparam int unsigned AddrW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CountW = $clog2(MAX_KEYS + 1);

  sapd_pkg::state_e state_q, state_d;

  logic [sapd_pkg::PadW-1:0]   pad_q, pad_d;
  logic [sapd_pkg::RowWW-1:0]  mrw_q, mrw_d;
  logic [sapd_pkg::CoordW-1:0] cur_x_q, cur_x_d;
  logic [sapd_pkg::CoordW-1:0] cur_y_q, cur_y_d;
  logic [sapd_pkg::DimW-1:0]   row_h_q, row_h_d;
  logic [sapd_pkg::CoordW-1:0] widest_q, widest_d;
  logic                        any_q, any_d;
  logic                        ovf_q, ovf_d;
  logic                        open_q, open_d;
  logic [CountW-1:0]           cnt_q, cnt_d;
  logic [CountW-1:0]           idx_q, idx_d;
  logic                        rdv_q, rdv_d;
  logic                        out_v_q, out_v_d;

  sapd_pkg::item_t   item_q, item_d;
  sapd_pkg::result_t wres_q, wres_d;
  sapd_pkg::result_t res_q, res_d;

  sapd_pkg::alu_op_t  alu_op;
  sapd_pkg::alu_res_t alu_res;

  logic [sapd_pkg::KeyW-1:0]   rd_key;
  logic                        rd_go;
  logic                        hit;
  logic                        wr_en;
  logic [sapd_pkg::PadW:0]     min_sz;
  logic [sapd_pkg::CoordW-1:0] new_x;

  sapd_adder u_adder (
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  sapd_key_store #(
    .MAX_KEYS (MAX_KEYS)
  ) u_key_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (cnt_q[AddrW-1:0]),
    .wr_key_i  (item_q.image_key),
    .rd_en_i   (rd_go),
    .rd_addr_i (idx_q[AddrW-1:0]),
    .rd_key_o  (rd_key)
  );

  assign cfg_i.ready = 1'b1;
  assign img_i.ready = (state_q == sapd_pkg::ST_IDLE);
  assign res_o.valid = out_v_q;
  assign res_o.data  = res_q;

  assign hit    = rdv_q && (rd_key == item_q.image_key);
  assign rd_go  = (state_q == sapd_pkg::ST_SEARCH) && (idx_q < cnt_q) && !hit;
  assign min_sz = {pad_q, 1'b1};
  assign new_x  = alu_res.sum[sapd_pkg::CoordW-1:0];

  always_comb begin
    state_d  = state_q;
    pad_d    = pad_q;
    mrw_d    = mrw_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    row_h_d  = row_h_q;
    widest_d = widest_q;
    any_d    = any_q;
    ovf_d    = ovf_q;
    open_d   = open_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    rdv_d    = rdv_q;
    out_v_d  = out_v_q;
    item_d   = item_q;
    wres_d   = wres_q;
    res_d    = res_q;
    wr_en    = 1'b0;

    if ((state_q == sapd_pkg::ST_WRAP) || (state_q == sapd_pkg::ST_FINAL)) begin
      alu_op = '{a: cur_y_q, b: row_h_q, c: pad_q};
    end else begin
      alu_op = '{a: cur_x_q, b: item_q.image_width, c: pad_q};
    end

    if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        sapd_pkg::CFG_ATLAS_PADDING: pad_d = cfg_i.data.value[sapd_pkg::PadW-1:0];
        sapd_pkg::CFG_MAX_ROW_WIDTH: mrw_d = cfg_i.data.value[sapd_pkg::RowWW-1:0];
        default: ;
      endcase
    end

    if (out_v_q && res_o.ready) begin
      out_v_d = 1'b0;
    end

    unique case (state_q)
      sapd_pkg::ST_IDLE: begin
        if (img_i.valid) begin
          item_d = img_i.data;
          wres_d = '0;
          idx_d  = '0;
          rdv_d  = 1'b0;
          if (!open_q) begin
            cur_x_d = sapd_pkg::CoordW'(pad_q);
            cur_y_d = sapd_pkg::CoordW'(pad_q);
            open_d  = 1'b1;
          end
          if (img_i.data.image_present) begin
            state_d = sapd_pkg::ST_SEARCH;
          end else if (img_i.data.last_item) begin
            state_d = sapd_pkg::ST_FINAL;
          end else begin
            state_d = sapd_pkg::ST_DONE;
          end
        end
      end
      sapd_pkg::ST_SEARCH: begin
        rdv_d = rd_go;
        if (rd_go) begin
          idx_d = idx_q + 1'b1;
        end
        if (hit) begin
          state_d = item_q.last_item ? sapd_pkg::ST_FINAL : sapd_pkg::ST_DONE;
        end else if (!rd_go && !rdv_q) begin
          if (cnt_q != CountW'(MAX_KEYS)) begin
            wr_en = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if ((item_q.image_width != '0) && (item_q.image_height != '0)) begin
            state_d = sapd_pkg::ST_ADVANCE;
          end else begin
            state_d = item_q.last_item ? sapd_pkg::ST_FINAL : sapd_pkg::ST_DONE;
          end
        end
      end
      sapd_pkg::ST_ADVANCE: begin
        if ((cur_x_q > sapd_pkg::CoordW'(pad_q))
            && (alu_res.sum > sapd_pkg::SumW'(mrw_q))) begin
          cur_x_d = sapd_pkg::CoordW'(pad_q);
          state_d = sapd_pkg::ST_WRAP;
        end else begin
          state_d = sapd_pkg::ST_PLACE;
        end
      end
      sapd_pkg::ST_WRAP: begin
        cur_y_d = alu_res.sat_val;
        row_h_d = '0;
        if (alu_res.sat) begin
          ovf_d = 1'b1;
        end
        state_d = sapd_pkg::ST_PLACE;
      end
      sapd_pkg::ST_PLACE: begin
        wres_d.placed  = 1'b1;
        wres_d.place_x = cur_x_q[sapd_pkg::XOutW-1:0];
        wres_d.place_y = cur_y_q;
        cur_x_d        = new_x;
        any_d          = 1'b1;
        if (item_q.image_height > row_h_q) begin
          row_h_d = item_q.image_height;
        end
        if (new_x > widest_q) begin
          widest_d = new_x;
        end
        state_d = item_q.last_item ? sapd_pkg::ST_FINAL : sapd_pkg::ST_DONE;
      end
      sapd_pkg::ST_FINAL: begin
        wres_d.is_final = 1'b1;
        if (any_q) begin
          if (widest_q > sapd_pkg::CoordW'(min_sz)) begin
            wres_d.atlas_width = widest_q[sapd_pkg::XOutW-1:0];
          end else begin
            wres_d.atlas_width = sapd_pkg::XOutW'(min_sz);
          end
          if (alu_res.sat_val > sapd_pkg::CoordW'(min_sz)) begin
            wres_d.atlas_height = alu_res.sat_val;
          end else begin
            wres_d.atlas_height = sapd_pkg::CoordW'(min_sz);
          end
          if (alu_res.sat) begin
            ovf_d = 1'b1;
          end
        end else begin
          wres_d.atlas_empty = 1'b1;
        end
        state_d = sapd_pkg::ST_DONE;
      end
      sapd_pkg::ST_DONE: begin
        if (!out_v_q || res_o.ready) begin
          out_v_d        = 1'b1;
          res_d          = wres_q;
          res_d.overflow = ovf_q;
          if (item_q.last_item) begin
            open_d   = 1'b0;
            row_h_d  = '0;
            widest_d = '0;
            any_d    = 1'b0;
            cnt_d    = '0;
            ovf_d    = 1'b0;
          end
          state_d = sapd_pkg::ST_IDLE;
        end
      end
      default: state_d = sapd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sapd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q    <= sapd_pkg::PadReset;
      mrw_q    <= sapd_pkg::RowWReset;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      row_h_q  <= '0;
      widest_q <= '0;
      any_q    <= 1'b0;
      ovf_q    <= 1'b0;
      open_q   <= 1'b0;
      cnt_q    <= '0;
      idx_q    <= '0;
      rdv_q    <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pad_q    <= pad_d;
      mrw_q    <= mrw_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      row_h_q  <= row_h_d;
      widest_q <= widest_d;
      any_q    <= any_d;
      ovf_q    <= ovf_d;
      open_q   <= open_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      rdv_q    <= rdv_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    wres_q <= wres_d;
    res_q  <= res_d;
  end

  `SAPD_ASSERT_NEXT(a_busy_after_take, img_i.valid && img_i.ready, state_q != sapd_pkg::ST_IDLE, "image taken but sequencer still idle")
  `SAPD_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CountW'(MAX_KEYS), "key count beyond store depth")
  `SAPD_ASSERT_IMPL(a_idx_bound, state_q == sapd_pkg::ST_SEARCH, idx_q <= cnt_q, "search index past stored keys")
  `SAPD_ASSERT_IMPL(a_cur_x_range, open_q, !cur_x_q[sapd_pkg::CoordW-1], "row cursor out of range")

endmodule
